/* design/hbpf_pkg.sv */
// Package with the types, character codes and command table of the packet framer.
package hbpf_pkg;

    localparam int unsigned MAX_PAYLOAD = 5;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data;
        logic       pending;
        logic [3:0] high;
    } hbpf_dec_t;

    typedef struct packed {
        logic       known;
        logic [2:0] len;
    } hbpf_cmd_info_t;

    function automatic hbpf_cmd_info_t cmd_lookup(input logic [7:0] cmd);
        hbpf_cmd_info_t info;
        info.known = 1'b1;
        case (cmd)
            8'h79: info.len = 3'd2;
            8'h81: info.len = 3'd1;
            8'h83: info.len = 3'd5;
            8'h8B: info.len = 3'd4;
            8'h85: info.len = 3'd4;
            8'h0A: info.len = 3'd1;
            8'h0C: info.len = 3'd1;
            8'h0D: info.len = 3'd1;
            8'h0F: info.len = 3'd2;
            8'h04: info.len = 3'd1;
            8'h1A: info.len = 3'd0;
            8'h11: info.len = 3'd1;
            8'h16: info.len = 3'd1;
            8'h82: info.len = 3'd1;
            8'h1D: info.len = 3'd1;
            8'h1F: info.len = 3'd3;
            default:
            begin
                info.known = 1'b0;
                info.len   = 3'd0;
            end
        endcase
        return info;
    endfunction

endpackage

/* design/hbpf_rx_if.sv */
// Interface for the channel that carries received serial bytes.
interface hbpf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* design/hbpf_pkt_if.sv */
// Interface for the channel that carries completed command packets.
interface hbpf_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] command;
    logic [2:0] payload_length;
    logic [7:0] payload_0;
    logic [7:0] payload_1;
    logic [7:0] payload_2;
    logic [7:0] payload_3;
    logic [7:0] payload_4;

    modport source (
        output valid, output command, output payload_length,
        output payload_0, output payload_1, output payload_2,
        output payload_3, output payload_4,
        input ready
    );
    modport sink (
        input valid, input command, input payload_length,
        input payload_0, input payload_1, input payload_2,
        input payload_3, input payload_4,
        output ready
    );
endinterface

/* design/hbpf_hex_decoder.sv */
// Hex pairing and separator filter that turns received bytes into framer bytes.
module hbpf_hex_decoder
    import hbpf_pkg::*;
(
    input  logic [7:0] rx_byte,
    input  logic       pending,
    input  logic [3:0] high,
    output hbpf_dec_t  dec
);

    logic       is_hex;
    logic [3:0] nibble;

    always_comb
    begin
        is_hex = 1'b1;
        nibble = 4'd0;
        if (rx_byte inside {[8'h30:8'h39]})
        begin
            nibble = rx_byte[3:0];
        end
        else if (rx_byte inside {[8'h41:8'h46], [8'h61:8'h66]})
        begin
            nibble = 4'(rx_byte[2:0] + 3'd1) + 4'd8;
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        dec.byte_valid = 1'b0;
        dec.data       = rx_byte;
        dec.pending    = pending;
        dec.high       = high;
        if (is_hex)
        begin
            if (!pending)
            begin
                dec.pending = 1'b1;
                dec.high    = nibble;
            end
            else
            begin
                dec.pending    = 1'b0;
                dec.byte_valid = 1'b1;
                dec.data       = {high, nibble};
            end
        end
        else if (!(rx_byte inside {CHAR_CR, CHAR_LF, CHAR_SPACE, CHAR_TAB}))
        begin
            dec.pending    = 1'b0;
            dec.byte_valid = 1'b1;
        end
    end

endmodule

/* design/hex_or_binary_command_packet_framer_core.sv */
// Top level of the hex or binary command packet framer.
// The block takes one received byte per clock cycle on rx and gives a completed packet on
// pkt in the cycle after the transfer of the byte that completes it; the packet sits in one
// output register, and rx stays ready while that register is empty or is being drained,
// so the input stalls only while a packet waits and the consumer holds pkt.ready low.
module hex_or_binary_command_packet_framer_core
    import hbpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hbpf_rx_if.sink    rx,
    hbpf_pkt_if.source pkt
);

    logic       nibble_pending_reg, nibble_pending_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       in_payload_reg, in_payload_next;
    logic [7:0] held_command_reg, held_command_next;
    logic [2:0] expected_length_reg, expected_length_next;
    logic [2:0] payload_count_reg, payload_count_next;
    logic [7:0] store_reg [MAX_PAYLOAD];
    logic [7:0] store_next [MAX_PAYLOAD];

    logic       pkt_valid_reg, pkt_valid_next;
    logic [7:0] command_reg;
    logic [2:0] length_reg;
    logic [7:0] payload_reg [MAX_PAYLOAD];

    logic           accept;
    logic           emit;
    logic [7:0]     emit_cmd;
    logic [2:0]     emit_len;
    logic [2:0]     count_plus;
    hbpf_dec_t      dec;
    hbpf_cmd_info_t info;

    hbpf_hex_decoder u_decoder (
        .rx_byte (rx.rx_byte),
        .pending (nibble_pending_reg),
        .high    (high_nibble_reg),
        .dec     (dec)
    );

    assign rx.ready   = !pkt_valid_reg || pkt.ready;
    assign accept     = rx.valid && rx.ready;
    assign info       = cmd_lookup(dec.data);
    assign count_plus = 3'(payload_count_reg + 3'd1);

    always_comb
    begin
        nibble_pending_next  = nibble_pending_reg;
        high_nibble_next     = high_nibble_reg;
        in_payload_next      = in_payload_reg;
        held_command_next    = held_command_reg;
        expected_length_next = expected_length_reg;
        payload_count_next   = payload_count_reg;
        store_next           = store_reg;
        emit                 = 1'b0;
        emit_cmd             = dec.data;
        emit_len             = 3'd0;
        if (accept)
        begin
            nibble_pending_next = dec.pending;
            high_nibble_next    = dec.high;
            if (dec.byte_valid)
            begin
                if (!in_payload_reg)
                begin
                    if (info.known)
                    begin
                        if (info.len == 3'd0)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            in_payload_next      = 1'b1;
                            held_command_next    = dec.data;
                            expected_length_next = info.len;
                            payload_count_next   = 3'd0;
                        end
                    end
                end
                else
                begin
                    if (payload_count_reg < 3'(MAX_PAYLOAD))
                    begin
                        store_next[payload_count_reg] = dec.data;
                    end
                    if (count_plus >= expected_length_reg)
                    begin
                        emit                 = 1'b1;
                        emit_cmd             = held_command_reg;
                        emit_len             = expected_length_reg;
                        in_payload_next      = 1'b0;
                        held_command_next    = 8'd0;
                        expected_length_next = 3'd0;
                        payload_count_next   = 3'd0;
                    end
                    else
                    begin
                        payload_count_next = count_plus;
                    end
                end
            end
        end
    end

    always_comb
    begin
        pkt_valid_next = pkt_valid_reg;
        if (emit)
        begin
            pkt_valid_next = 1'b1;
        end
        else if (pkt.ready)
        begin
            pkt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_pending_reg  <= 1'b0;
            high_nibble_reg     <= 4'd0;
            in_payload_reg      <= 1'b0;
            held_command_reg    <= 8'd0;
            expected_length_reg <= 3'd0;
            payload_count_reg   <= 3'd0;
            pkt_valid_reg       <= 1'b0;
        end
        else
        begin
            nibble_pending_reg  <= nibble_pending_next;
            high_nibble_reg     <= high_nibble_next;
            in_payload_reg      <= in_payload_next;
            held_command_reg    <= held_command_next;
            expected_length_reg <= expected_length_next;
            payload_count_reg   <= payload_count_next;
            pkt_valid_reg       <= pkt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        if (emit)
        begin
            command_reg <= emit_cmd;
            length_reg  <= emit_len;
            for (int i = 0; i < MAX_PAYLOAD; i++)
            begin
                payload_reg[i] <= (3'(i) < emit_len) ? store_next[i] : 8'd0;
            end
        end
    end

    assign pkt.valid          = pkt_valid_reg;
    assign pkt.command        = command_reg;
    assign pkt.payload_length = length_reg;
    assign pkt.payload_0      = payload_reg[0];
    assign pkt.payload_1      = payload_reg[1];
    assign pkt.payload_2      = payload_reg[2];
    assign pkt.payload_3      = payload_reg[3];
    assign pkt.payload_4      = payload_reg[4];

endmodule

/* design/hbpf_checker.sv */
// Port checker for the packet framer and the bind that attaches it to the top level.
module hbpf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic       pkt_valid,
    input logic       pkt_ready,
    input logic [7:0] command,
    input logic [2:0] payload_length,
    input logic [7:0] payload_0,
    input logic [7:0] payload_1,
    input logic [7:0] payload_2,
    input logic [7:0] payload_3,
    input logic [7:0] payload_4
);

    // A packet never claims more payload bytes than the table allows.
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid |-> payload_length <= 3'd5)
        else $error("packet length above five");

    // Payload bytes past the packet length read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid |->
            (payload_length > 3'd0 || payload_0 == 8'd0) &&
            (payload_length > 3'd1 || payload_1 == 8'd0) &&
            (payload_length > 3'd2 || payload_2 == 8'd0) &&
            (payload_length > 3'd3 || payload_3 == 8'd0) &&
            (payload_length > 3'd4 || payload_4 == 8'd0))
        else $error("unused payload byte is not zero");

    // The input side is open whenever no packet waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pkt_valid |-> rx_ready)
        else $error("input stalled with an empty output register");

    // A new packet only follows an input transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pkt_valid) |-> $past(rx_valid && rx_ready))
        else $error("packet appeared without an input transfer");

    // A stalled packet holds its command, its length and its first and last payload bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && !pkt_ready |=> pkt_valid && $stable(command) &&
            $stable(payload_length) && $stable(payload_0) && $stable(payload_4))
        else $error("stalled packet changed");

endmodule

bind hex_or_binary_command_packet_framer_core hbpf_checker u_hbpf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rx_valid       (rx.valid),
    .rx_ready       (rx.ready),
    .pkt_valid      (pkt.valid),
    .pkt_ready      (pkt.ready),
    .command        (pkt.command),
    .payload_length (pkt.payload_length),
    .payload_0      (pkt.payload_0),
    .payload_1      (pkt.payload_1),
    .payload_2      (pkt.payload_2),
    .payload_3      (pkt.payload_3),
    .payload_4      (pkt.payload_4)
);
